FILE: rtl/rhd_pkg.sv
package rhd_pkg;

	localparam int POSITION_BITS_DEF = 40;
	localparam int POS_OUT_BITS      = 40;
	localparam int SIZE_BITS         = 37;
	localparam int LEAD_BYTES        = 96;
	localparam int PREAMBLE_BYTES    = 16;
	localparam logic [SIZE_BITS-1:0] MAX_REGION_RESET = SIZE_BITS'(64 * 1024 * 1024);
	localparam logic [7:0] HDR_VERSION = 8'h01;

	typedef enum logic [2:0] {
		PH_LEAD     = 3'd0,
		PH_SIGPRE   = 3'd1,
		PH_SIGBODY  = 3'd2,
		PH_PAD      = 3'd3,
		PH_MAINPRE  = 3'd4,
		PH_MAINBODY = 3'd5,
		PH_PAYLOAD  = 3'd6,
		PH_ERROR    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_VER   = 3'd3,
		ST_TRUNC     = 3'd4,
		ST_SIZE      = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              region;
		logic [POS_OUT_BITS-1:0] position;
		logic [2:0]              status;
		logic                    payload_start;
	} out_item_t;

	function automatic logic [7:0] lead_magic(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'hed;
			2'd1: v = 8'hab;
			2'd2: v = 8'hee;
			2'd3: v = 8'hdb;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] hdr_magic(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'h8e;
			2'd1: v = 8'had;
			2'd2: v = 8'he8;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/rhd_core.sv
module rhd_core #(
	parameter int POSITION_BITS = rhd_pkg::POSITION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_en,
	input  rhd_pkg::in_item_t                   item,
	input  logic [rhd_pkg::SIZE_BITS-1:0]       max_bytes,
	output rhd_pkg::out_item_t                  res
);

	localparam int SB = rhd_pkg::SIZE_BITS;

	rhd_pkg::phase_t      phase_q, n_phase;
	rhd_pkg::status_t     err_q, n_err, err_new;
	logic [POSITION_BITS-1:0] offset_q, n_offset;
	logic [3:0]           pidx_q, n_pidx;
	logic [SB-1:0]        remain_q, n_remain;
	logic [31:0]          icount_q, n_icount;
	logic [31:0]          dlen_q, n_dlen;
	logic [SB-1:0]        body;
	logic [SB:0]          total;
	logic [2:0]           pad;
	logic [7:0]           b;
	logic                 pstart;
	logic [63:0]          pos_wide;

	always_comb begin
		b        = item.data_byte;
		n_phase  = phase_q;
		n_err    = err_q;
		err_new  = rhd_pkg::ST_OK;
		n_offset = offset_q;
		n_pidx   = pidx_q;
		n_remain = remain_q;
		n_icount = icount_q;
		n_dlen   = dlen_q;
		pstart   = 1'b0;
		// pad to 8-byte alignment after this byte: (8 - ((pos + 1) & 7)) & 7
		pad      = ~offset_q[2:0];
		body     = '0;
		total    = '0;

		unique case (phase_q)
			rhd_pkg::PH_LEAD: begin
				if (offset_q < POSITION_BITS'(4) && b != rhd_pkg::lead_magic(offset_q[1:0]))
					err_new = rhd_pkg::ST_BAD_LEAD;
				else if (offset_q >= POSITION_BITS'(rhd_pkg::LEAD_BYTES - 1)) begin
					n_phase = rhd_pkg::PH_SIGPRE;
					n_pidx  = '0;
				end
			end
			rhd_pkg::PH_SIGPRE, rhd_pkg::PH_MAINPRE: begin
				priority if (pidx_q < 4'd3 && b != rhd_pkg::hdr_magic(pidx_q[1:0]))
					err_new = rhd_pkg::ST_BAD_MAGIC;
				else if (pidx_q == 4'd3 && b != rhd_pkg::HDR_VERSION)
					err_new = rhd_pkg::ST_BAD_VER;
				else if (pidx_q >= 4'd8 && pidx_q <= 4'd11)
					n_icount = {icount_q[23:0], b};
				else if (pidx_q >= 4'd12)
					n_dlen = {dlen_q[23:0], b};
				else
					n_dlen = dlen_q;
				body  = {1'b0, n_icount, 4'b0000} + {5'b00000, n_dlen};
				total = {1'b0, body} + (SB+1)'(rhd_pkg::PREAMBLE_BYTES);
				if (err_new == rhd_pkg::ST_OK) begin
					if (pidx_q == 4'd15) begin
						if (total > {1'b0, max_bytes})
							err_new = rhd_pkg::ST_SIZE;
						else begin
							n_phase  = rhd_pkg::phase_t'(phase_q + 3'd1);
							n_remain = body;
							// empty body: jump straight past it
							if (body == '0) begin
								if (phase_q == rhd_pkg::PH_SIGPRE) begin
									if (pad != 3'd0) begin
										n_phase  = rhd_pkg::PH_PAD;
										n_remain = SB'(pad);
									end else begin
										n_phase = rhd_pkg::PH_MAINPRE;
										n_pidx  = '0;
									end
								end else begin
									n_phase = rhd_pkg::PH_PAYLOAD;
									n_pidx  = '0;
								end
							end
						end
					end else begin
						n_pidx = pidx_q + 4'd1;
					end
				end
			end
			rhd_pkg::PH_SIGBODY, rhd_pkg::PH_MAINBODY: begin
				if (remain_q != '0)
					n_remain = remain_q - SB'(1);
				if (n_remain == '0) begin
					if (phase_q == rhd_pkg::PH_SIGBODY) begin
						if (pad != 3'd0) begin
							n_phase  = rhd_pkg::PH_PAD;
							n_remain = SB'(pad);
						end else begin
							n_phase = rhd_pkg::PH_MAINPRE;
							n_pidx  = '0;
						end
					end else begin
						n_phase = rhd_pkg::PH_PAYLOAD;
						n_pidx  = '0;
					end
				end
			end
			rhd_pkg::PH_PAD: begin
				if (remain_q != '0)
					n_remain = remain_q - SB'(1);
				if (n_remain == '0) begin
					n_phase = rhd_pkg::PH_MAINPRE;
					n_pidx  = '0;
				end
			end
			rhd_pkg::PH_PAYLOAD: begin
				// preamble index doubles as the "first payload byte seen" mark
				if (pidx_q == 4'd0) begin
					pstart = 1'b1;
					n_pidx = 4'd1;
				end
			end
			rhd_pkg::PH_ERROR: begin
			end
			default: begin
			end
		endcase

		if (err_new != rhd_pkg::ST_OK && err_q == rhd_pkg::ST_OK) begin
			n_err   = err_new;
			n_phase = rhd_pkg::PH_ERROR;
		end
		if (item.last_byte && n_err == rhd_pkg::ST_OK && n_phase < rhd_pkg::PH_PAYLOAD) begin
			n_err   = rhd_pkg::ST_TRUNC;
			n_phase = rhd_pkg::PH_ERROR;
		end

		pos_wide          = 64'(offset_q);
		res.region        = (n_err != rhd_pkg::ST_OK) ? 3'(rhd_pkg::PH_ERROR) : 3'(phase_q);
		res.position      = pos_wide[rhd_pkg::POS_OUT_BITS-1:0];
		res.status        = 3'(n_err);
		res.payload_start = (n_err == rhd_pkg::ST_OK) ? pstart : 1'b0;

		if (offset_q != '1)
			n_offset = offset_q + POSITION_BITS'(1);

		// end of file: start over for the next one
		if (item.last_byte) begin
			n_phase  = rhd_pkg::PH_LEAD;
			n_err    = rhd_pkg::ST_OK;
			n_offset = '0;
			n_pidx   = '0;
			n_remain = '0;
			n_icount = '0;
			n_dlen   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rhd_pkg::PH_LEAD;
			err_q    <= rhd_pkg::ST_OK;
			offset_q <= '0;
			pidx_q   <= '0;
			remain_q <= '0;
			icount_q <= '0;
			dlen_q   <= '0;
		end else if (step_en) begin
			phase_q  <= n_phase;
			err_q    <= n_err;
			offset_q <= n_offset;
			pidx_q   <= n_pidx;
			remain_q <= n_remain;
			icount_q <= n_icount;
			dlen_q   <= n_dlen;
		end
	end

endmodule

FILE: rtl/rpm_header_region_deframer_top.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data (data_byte, last_byte)
// out     | output    | out_valid / out_ready | out_data (region, position, status,
//         |           |                       |           payload_start)
// cfg     | input     | cfg_wen, no wait      | cfg_wdata (max_region_bytes)
//
// one byte per clock sustained while out is not stalled; an accepted byte reaches out
// through the input register, then the region/status logic into the result register
// arst_n clears parser state and sets max_region_bytes to 64 MiB
// a stalled out holds its result while the input register still takes one more byte;
// in_ready drops only when both registers are full and out is stalled
module rpm_header_region_deframer_top #(
	parameter int POSITION_BITS = rhd_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rhd_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rhd_pkg::out_item_t            out_data,
	input  logic                          cfg_wen,
	input  logic [rhd_pkg::SIZE_BITS-1:0] cfg_wdata
);

	logic                          valid_s1, valid_s2, step_en;
	rhd_pkg::in_item_t             item_s1;
	rhd_pkg::out_item_t            res, res_s2;
	logic [rhd_pkg::SIZE_BITS-1:0] max_q;

	assign step_en   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || step_en;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= rhd_pkg::MAX_REGION_RESET;
		end else if (cfg_wen) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (step_en)
				valid_s1 <= 1'b0;
			if (step_en)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (step_en)
			res_s2 <= res;
	end

	rhd_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.item      (item_s1),
		.max_bytes (max_q),
		.res       (res)
	);

endmodule

FILE: rtl/rhd_checker.sv
module rhd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input rhd_pkg::out_item_t out_data
);

	// any error status forces the error region
	a_err_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != 3'(rhd_pkg::ST_OK)
			|-> out_data.region == 3'(rhd_pkg::PH_ERROR))
		else $error("error status without error region");

	a_ok_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == 3'(rhd_pkg::ST_OK)
			|-> out_data.region != 3'(rhd_pkg::PH_ERROR))
		else $error("error region with ok status");

	a_pstart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.payload_start
			|-> out_data.region == 3'(rhd_pkg::PH_PAYLOAD)
				&& out_data.status == 3'(rhd_pkg::ST_OK))
		else $error("payload start outside payload");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= 3'(rhd_pkg::ST_SIZE))
		else $error("status code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind rpm_header_region_deframer_top rhd_checker u_rhd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: tb/region_tag_checker.sv
`timescale 1ns / 1ps

module region_tag_checker
	import rhd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_wen,
	input  logic [SIZE_BITS-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   outstanding,
	output int                   checked
);

	localparam logic [31:0] LEAD_MAGIC = 32'hedabeedb;
	localparam logic [23:0] HDR_MAGIC  = 24'h8eade8;

	// tagging state of the file in progress
	phase_t                cur_phase;
	logic [POS_OUT_BITS-1:0] offset;
	logic [3:0]            pre_count;
	logic [SIZE_BITS-1:0]  left_bytes;
	logic [31:0]           hdr_entries;
	logic [31:0]           hdr_data_len;
	status_t               sticky_status;
	logic [SIZE_BITS-1:0]  size_limit;

	out_item_t expected_tags[$];
	out_item_t want;

	function automatic void restart();
		cur_phase     = PH_LEAD;
		offset        = '0;
		pre_count     = '0;
		left_bytes    = '0;
		hdr_entries   = '0;
		hdr_data_len  = '0;
		sticky_status = ST_OK;
	endfunction

	function automatic void header_done(input logic [POS_OUT_BITS-1:0] pos);
		logic [2:0] pad;
		if (cur_phase == PH_SIGBODY) begin
			// bytes left up to the next 8-byte boundary
			pad = 3'd0 - (pos[2:0] + 3'd1);
			if (pad != 3'd0) begin
				cur_phase  = PH_PAD;
				left_bytes = SIZE_BITS'(pad);
			end else begin
				cur_phase = PH_MAINPRE;
				pre_count = '0;
			end
		end else begin
			cur_phase = PH_PAYLOAD;
			pre_count = '0;
		end
	endfunction

	function automatic out_item_t tag_byte(input in_item_t item);
		out_item_t   t;
		phase_t      seen;
		status_t     err;
		logic [3:0]  k;
		logic [38:0] total;
		logic        opens_payload;
		seen          = cur_phase;
		err           = ST_OK;
		opens_payload = 1'b0;
		case (cur_phase)
			PH_LEAD: begin
				if (offset < 4 && item.data_byte != LEAD_MAGIC[8*(3-int'(offset[1:0])) +: 8])
					err = ST_BAD_LEAD;
				else if (offset >= POS_OUT_BITS'(LEAD_BYTES - 1)) begin
					cur_phase = PH_SIGPRE;
					pre_count = '0;
				end
			end
			PH_SIGPRE, PH_MAINPRE: begin
				k = pre_count;
				if (k < 3 && item.data_byte != HDR_MAGIC[8*(2-int'(k)) +: 8])
					err = ST_BAD_MAGIC;
				else if (k == 3 && item.data_byte != HDR_VERSION)
					err = ST_BAD_VER;
				else if (k >= 8 && k <= 11)
					hdr_entries = {hdr_entries[23:0], item.data_byte};
				else if (k >= 12)
					hdr_data_len = {hdr_data_len[23:0], item.data_byte};
				if (err == ST_OK) begin
					if (k == 4'd15) begin
						total = {3'b0, hdr_entries, 4'b0} + 39'(hdr_data_len) + 39'd16;
						if (total > 39'(size_limit)) begin
							err = ST_SIZE;
						end else begin
							cur_phase  = phase_t'(cur_phase + 3'd1);
							left_bytes = SIZE_BITS'(total - 39'd16);
							if (left_bytes == '0)
								header_done(offset);
						end
					end else begin
						pre_count = k + 4'd1;
					end
				end
			end
			PH_SIGBODY, PH_MAINBODY: begin
				if (left_bytes != '0)
					left_bytes = left_bytes - SIZE_BITS'(1);
				if (left_bytes == '0)
					header_done(offset);
			end
			PH_PAD: begin
				if (left_bytes != '0)
					left_bytes = left_bytes - SIZE_BITS'(1);
				if (left_bytes == '0) begin
					cur_phase = PH_MAINPRE;
					pre_count = '0;
				end
			end
			PH_PAYLOAD: begin
				if (pre_count == '0) begin
					opens_payload = 1'b1;
					pre_count     = 4'd1;
				end
			end
			default: ;
		endcase

		if (err != ST_OK && sticky_status == ST_OK) begin
			sticky_status = err;
			cur_phase     = PH_ERROR;
		end
		// file ended before the main header was complete
		if (item.last_byte && sticky_status == ST_OK && cur_phase < PH_PAYLOAD) begin
			sticky_status = ST_TRUNC;
			cur_phase     = PH_ERROR;
		end

		t.region        = (sticky_status != ST_OK) ? PH_ERROR : seen;
		t.position      = offset;
		t.status        = sticky_status;
		t.payload_start = (sticky_status == ST_OK) && opens_payload;

		if (offset != '1)
			offset = offset + POS_OUT_BITS'(1);
		if (item.last_byte)
			restart();
		return t;
	endfunction

	function automatic void check_field(input string name, input logic [POS_OUT_BITS-1:0] exp_v,
			input logic [POS_OUT_BITS-1:0] got_v);
		if (exp_v !== got_v) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			size_limit = MAX_REGION_RESET;
			expected_tags.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tags.size() == 0) begin
					fail_count++;
					$error("result transaction with no byte waiting, position %0d",
						out_data.position);
				end else begin
					want = expected_tags.pop_front();
					check_field("region", POS_OUT_BITS'(want.region),
						POS_OUT_BITS'(out_data.region));
					check_field("position", want.position, out_data.position);
					check_field("status", POS_OUT_BITS'(want.status),
						POS_OUT_BITS'(out_data.status));
					check_field("payload_start", POS_OUT_BITS'(want.payload_start),
						POS_OUT_BITS'(out_data.payload_start));
					checked++;
				end
			end
			if (in_valid && in_ready)
				expected_tags.insert(expected_tags.size(), tag_byte(in_data));
			if (cfg_wen)
				size_limit = cfg_wdata;
			outstanding = expected_tags.size();
		end
	end

endmodule

FILE: tb/rpm_header_region_deframer_top_tb.sv
`timescale 1ns / 1ps

module rpm_header_region_deframer_top_tb;
	import rhd_pkg::*;

	localparam logic [31:0] LEAD_MAGIC = 32'hedabeedb;
	localparam logic [23:0] HDR_MAGIC  = 24'h8eade8;
	localparam int RANDOM_BYTES = 400;
	localparam int LONG_HOLD    = 64;
	localparam int NUM_KINDS    = 9;

	typedef enum int {
		FK_GOOD, FK_EMPTY, FK_BAD_LEAD, FK_BAD_MAGIC, FK_BAD_VER,
		FK_TOO_BIG, FK_CUT, FK_CUT_HUGE, FK_NOISE
	} file_kind_t;

	// cheap error files first so the byte budget reaches more kinds
	localparam file_kind_t KIND_ORDER[NUM_KINDS] = '{
		FK_BAD_LEAD, FK_TOO_BIG, FK_GOOD, FK_BAD_VER, FK_NOISE,
		FK_CUT, FK_BAD_MAGIC, FK_EMPTY, FK_CUT_HUGE
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_wen   = 1'b0;
	logic [SIZE_BITS-1:0] cfg_wdata = '0;

	int fail_count;
	int outstanding;
	int checked;

	logic [7:0]           file_q[$];
	int                   sig_at, main_at, main_end;
	logic [SIZE_BITS-1:0] cur_limit = MAX_REGION_RESET;
	int                   files_sent, bytes_sent, limits_used;
	int                   hold_requests, holds_done;

	always #10 clk = ~clk;

	rpm_header_region_deframer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	region_tag_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		#10_000_000;
		$display("rpm_header_region_deframer_top: mismatch");
		$finish;
	end

	// file building
	function automatic void append_byte(input logic [7:0] v);
		file_q.insert(file_q.size(), v);
	endfunction

	function automatic void put_lead();
		file_q.delete();
		for (int i = 3; i >= 0; i--)
			append_byte(LEAD_MAGIC[8*i +: 8]);
		repeat (LEAD_BYTES - 4)
			append_byte(8'($urandom));
		sig_at = file_q.size();
	endfunction

	function automatic void put_header(input logic [31:0] entries, input logic [31:0] dlen,
			input bit fill);
		for (int i = 2; i >= 0; i--)
			append_byte(HDR_MAGIC[8*i +: 8]);
		append_byte(HDR_VERSION);
		repeat (4)
			append_byte(8'($urandom));
		for (int i = 3; i >= 0; i--)
			append_byte(entries[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			append_byte(dlen[8*i +: 8]);
		if (fill)
			repeat (entries * 16 + dlen)
				append_byte(8'($urandom));
	endfunction

	function automatic void put_pad();
		while (file_q.size() % 8 != 0)
			append_byte(8'($urandom));
		main_at = file_q.size();
	endfunction

	function automatic void cut_to(input int n);
		while (file_q.size() > n)
			file_q.delete(file_q.size() - 1);
	endfunction

	// small header body that still fits the current limit
	function automatic void pick_body(output logic [31:0] entries, output logic [31:0] dlen);
		entries = $urandom_range(0, 1);
		dlen    = $urandom_range(0, 20);
		if ($urandom_range(0, 3) == 0) begin
			entries = 0;
			dlen    = 0;
		end
		if (64'(entries) * 16 + 64'(dlen) + 16 > 64'(cur_limit)) begin
			entries = 0;
			dlen    = (64'(cur_limit) - 16 < 20) ? 32'(cur_limit - 16) : 32'd20;
		end
	endfunction

	function automatic void make_file(input file_kind_t kind);
		logic [31:0] es, ds, em, dm;
		int          hdr, j;
		case (kind)
			FK_GOOD, FK_EMPTY, FK_CUT, FK_BAD_MAGIC, FK_BAD_VER: begin
				if (kind == FK_EMPTY) begin
					es = 0; ds = 0; em = 0; dm = 0;
				end else begin
					pick_body(es, ds);
					pick_body(em, dm);
				end
				put_lead();
				put_header(es, ds, 1);
				put_pad();
				put_header(em, dm, 1);
				main_end = file_q.size() - 1;
				repeat ($urandom_range(0, 12))
					append_byte(8'($urandom));
				hdr = $urandom_range(0, 1) ? sig_at : main_at;
				if (kind == FK_CUT) begin
					cut_to($urandom_range(0, 1) ? $urandom_range(1, main_end)
						: $urandom_range(sig_at + 1, main_end));
				end else if (kind == FK_BAD_MAGIC || kind == FK_BAD_VER) begin
					j = (kind == FK_BAD_VER) ? 3 : $urandom_range(0, 2);
					file_q[hdr + j] ^= 8'($urandom_range(1, 255));
					cut_to(hdr + j + 1 + $urandom_range(0, 6));
				end
			end
			FK_BAD_LEAD: begin
				put_lead();
				j = $urandom_range(0, 3);
				file_q[j] ^= 8'($urandom_range(1, 255));
				cut_to(j + 1 + $urandom_range(0, 5));
			end
			FK_TOO_BIG, FK_CUT_HUGE: begin
				put_lead();
				if ($urandom_range(0, 1)) begin
					pick_body(es, ds);
					put_header(es, ds, 1);
					put_pad();
				end
				em = $urandom;
				dm = $urandom;
				if (kind == FK_TOO_BIG) begin
					// one byte over the limit, or a huge entry count that is over all but the largest limits
					if ($urandom_range(0, 1) && 64'(cur_limit) - 15 <= 64'hffff_ffff) begin
						em = 0;
						dm = 32'(cur_limit - 15);
					end else begin
						em = em | 32'hf000_0000;
					end
				end
				put_header(em, dm, 0);
				repeat ($urandom_range(0, 8))
					append_byte(8'($urandom));
			end
			default: begin
				file_q.delete();
				repeat ($urandom_range(1, 8))
					append_byte(8'($urandom));
				if ($urandom_range(0, 1))
					file_q[0] = LEAD_MAGIC[31:24];
			end
		endcase
	endfunction

	function automatic file_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8 || r >= 18)
			return FK_GOOD;
		else if (r < 10)
			return FK_EMPTY;
		else if (r < 15)
			return file_kind_t'(r - 8);
		else if (r < 16)
			return FK_CUT;
		else if (r < 17)
			return FK_CUT_HUGE;
		return FK_NOISE;
	endfunction

	task automatic send_file(input bit calm);
		in_item_t item;
		int       gap;
		for (int i = 0; i < file_q.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			item.data_byte = file_q[i];
			item.last_byte = (i == file_q.size() - 1);
			@(negedge clk);
			in_data  <= item;
			in_valid <= 1'b1;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		files_sent++;
		bytes_sent += file_q.size();
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [SIZE_BITS-1:0] lim);
		drain();
		cfg_wdata <= lim;
		cfg_wen   <= 1'b1;
		@(negedge clk) cfg_wen <= 1'b0;
		cur_limit = lim;
		limits_used++;
	endtask

	function automatic logic [SIZE_BITS-1:0] limit_for(input int n);
		logic [SIZE_BITS-1:0] v;
		case (n % 5)
			0: v = SIZE_BITS'(16);
			1: v = '1;
			2: v = SIZE_BITS'($urandom_range(16, 120));
			3: begin
				v = SIZE_BITS'({$urandom, $urandom});
				if (v < 16)
					v = SIZE_BITS'(16);
			end
			default: v = MAX_REGION_RESET;
		endcase
		return v;
	endfunction

	// result side: random stalls, calm stretches, and one long hold-off on request
	initial begin : receiver
		int stall;
		int taken;
		bit calm;
		taken = 0;
		calm  = 1'b0;
		wait (arst_n);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done++;
				@(negedge clk) out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end
			if (taken % 48 == 0)
				calm = ($urandom_range(0, 2) == 0);
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int          rand_bytes;
		int          kind_idx;
		int          rand_files;
		file_kind_t  kind;
		rand_bytes  = 0;
		kind_idx    = 0;
		rand_files  = 0;
		limits_used = 1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short files: lead magic edge cases, data extremes, early ends
		file_q = '{8'hed};
		send_file(1'b0);
		file_q = '{8'h00};
		send_file(1'b0);
		file_q = '{8'hff};
		send_file(1'b1);
		file_q = '{8'hed, 8'hab, 8'hee, 8'hdb};
		send_file(1'b0);
		file_q = '{8'hed, 8'hab, 8'hee, 8'h00, 8'h55, 8'hff};
		send_file(1'b1);
		file_q = '{8'hed, 8'h2b, 8'hff, 8'h00, 8'hed};
		send_file(1'b0);

		while (rand_bytes < RANDOM_BYTES) begin
			if (rand_files % 2 == 0)
				set_limit(limit_for(rand_files / 2));
			kind = (kind_idx < NUM_KINDS) ? KIND_ORDER[kind_idx] : pick_kind();
			kind_idx++;
			make_file(kind);
			// stall the result side once while a good file streams in
			if (kind == FK_GOOD && hold_requests == 0)
				hold_requests++;
			send_file($urandom_range(0, 3) == 0);
			rand_bytes += file_q.size();
			rand_files++;
		end

		drain();
		repeat (10) @(negedge clk);
		$display("covered %0d files, %0d bytes under %0d size limits (16 and max among them)",
			files_sent, bytes_sent, limits_used);
		$display("%0d tagged bytes compared", checked);
		if (fail_count == 0 && outstanding == 0)
			$display("rpm_header_region_deframer_top: match");
		else
			$display("rpm_header_region_deframer_top: mismatch");
		$finish;
	end

endmodule
